[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define FLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define FLP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/fl_ptw_pkg.sv]
`default_nettype none

package fl_ptw_pkg;

  // Fixed field geometry
  localparam int IDX_W       = 9;
  localparam int ENTRIES     = 512;
  localparam int ENTRY_W     = 64;
  localparam int FRAME_SHIFT = 12;
  localparam int PAGE_W      = 52;
  localparam int VPN_W       = 45;
  localparam int ROOT_W      = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam logic [6:0] FIRST_FREE_RST = 7'd1;

  // Item kinds
  localparam logic [1:0] KIND_QUERY  = 2'd0;
  localparam logic [1:0] KIND_MAP    = 2'd1;
  localparam logic [1:0] KIND_UNMAP  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE_FRAME = 2'd1;

  typedef struct packed {
    logic [1:0]        kind;
    logic [VPN_W-1:0]  virtual_page;
    logic [PAGE_W-1:0] physical_page;
  } in_item_t;

  typedef struct packed {
    logic              mapped;
    logic [PAGE_W-1:0] found_page;
    logic              out_of_frames;
  } out_item_t;

  // What a table write stores
  typedef enum logic [1:0] {
    WR_ALLOC = 2'd0,
    WR_LEAF  = 2'd1,
    WR_UNMAP = 2'd2
  } wr_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    rd;
    logic    wr;
    wr_sel_t wr_sel;
    logic    descend_entry;
    logic    descend_fresh;
    logic    finish;
    logic    fin_hit;
    logic    fin_oof;
    logic    clear_step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] in_kind;
    logic [1:0] kind;
    logic       ent_valid;
    logic       last;
    logic       exhausted;
    logic       clear_last;
  } sts_t;

endpackage

`default_nettype wire

[design/five_level_page_table_walker_unit.sv]
// Walk: query and unmap read and check the entry at each level, ending early at an invalid
//   entry; map writes the leaf without reading it, or ends when frames run out. The result strobe is registered.
// Throughput: one item at a time, set by the single table port (at most one access a cycle);
//   the next start is taken in the cycle the result is shown.
// Reset: a clear pass zeroes the table with busy high; configuration writes are taken
//   meanwhile. The receiver cannot stall.
`default_nettype none

module five_level_page_table_walker_unit
  import fl_ptw_pkg::*;
#(
  parameter int NUM_FRAMES = 64,
  parameter int LEVELS     = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // Registers are always writable
  assign cfg_ready = 1'b1;

  fl_ptw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  fl_ptw_dp #(
    .NUM_FRAMES (NUM_FRAMES),
    .LEVELS     (LEVELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

`default_nettype wire

[design/fl_ptw_ctrl.sv]
`default_nettype none

module fl_ptw_ctrl
  import fl_ptw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_CHECK = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Walk sequencing: at most one table access per cycle
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (sts.in_kind == KIND_UNUSED) begin
            cmd.finish = 1'b1;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        // map needs no read of the leaf, it just writes it
        if (sts.kind == KIND_MAP && sts.last) begin
          cmd.wr     = 1'b1;
          cmd.wr_sel = WR_LEAF;
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        case (sts.kind)
          KIND_QUERY: begin
            if (sts.last) begin
              cmd.finish  = 1'b1;
              cmd.fin_hit = sts.ent_valid;
              state_nxt   = S_IDLE;
            end else if (!sts.ent_valid) begin
              cmd.finish = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              cmd.descend_entry = 1'b1;
              state_nxt         = S_READ;
            end
          end
          KIND_MAP: begin
            if (sts.ent_valid) begin
              cmd.descend_entry = 1'b1;
              state_nxt         = S_READ;
            end else if (sts.exhausted) begin
              cmd.finish  = 1'b1;
              cmd.fin_oof = 1'b1;
              state_nxt   = S_IDLE;
            end else begin
              cmd.wr            = 1'b1;
              cmd.wr_sel        = WR_ALLOC;
              cmd.descend_fresh = 1'b1;
              state_nxt         = S_READ;
            end
          end
          KIND_UNMAP: begin
            if (sts.last) begin
              cmd.wr     = 1'b1;
              cmd.wr_sel = WR_UNMAP;
              cmd.finish = 1'b1;
              state_nxt  = S_IDLE;
            end else if (!sts.ent_valid) begin
              cmd.finish = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              cmd.descend_entry = 1'b1;
              state_nxt         = S_READ;
            end
          end
          default: begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/fl_ptw_dp.sv]
`default_nettype none

module fl_ptw_dp
  import fl_ptw_pkg::*;
#(
  parameter int NUM_FRAMES = 64,
  parameter int LEVELS     = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire in_item_t              in_data,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  output logic                       out_valid,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int FRAME_W   = $clog2(NUM_FRAMES);
  localparam int ADDR_W    = FRAME_W + IDX_W;
  localparam int MEM_DEPTH = NUM_FRAMES * ENTRIES;
  localparam int NF_CNT_W  = $clog2(NUM_FRAMES + 1);
  localparam int NF_W      = (NF_CNT_W > CFG_DATA_W) ? NF_CNT_W : CFG_DATA_W;
  localparam int VSH_W     = LEVELS * IDX_W;
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [PAGE_W-1:0] NF_PAGE   = PAGE_W'(NUM_FRAMES);
  localparam logic [NF_W-1:0]   NF_LIMIT  = NF_W'(NUM_FRAMES);
  localparam logic [LVL_W-1:0]  LVL_LAST  = LVL_W'(LEVELS - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MEM_DEPTH - 1);

  // Table memory, single port, registered read
  logic [ENTRY_W-1:0] mem [MEM_DEPTH];

  logic [1:0]         kind_r;
  logic [VSH_W-1:0]   vsh_r;
  logic [PAGE_W-1:0]  ppn_r;
  logic [FRAME_W-1:0] frame_r;
  logic               frame_ok_r;
  logic [LVL_W-1:0]   lvl_r;
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ROOT_W-1:0]  root_r;
  logic [NF_W-1:0]    next_frame_r;
  logic [ADDR_W-1:0]  clr_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [IDX_W-1:0]   idx;
  logic [ADDR_W-1:0]  addr;
  logic               we;
  logic [ENTRY_W-1:0] wdata;
  logic [PAGE_W-1:0]  ent_frame;
  logic               ent_ok;

  assign idx       = vsh_r[VSH_W-1 -: IDX_W];
  assign ent_frame = rd_data_r[ENTRY_W-1:FRAME_SHIFT];
  assign ent_ok    = (ent_frame < NF_PAGE);

  // Status back to the controller
  assign sts.in_kind    = in_data.kind;
  assign sts.kind       = kind_r;
  assign sts.ent_valid  = frame_ok_r & rd_data_r[0];
  assign sts.last       = (lvl_r == LVL_LAST);
  assign sts.exhausted  = (next_frame_r >= NF_LIMIT);
  assign sts.clear_last = (clr_r == ADDR_LAST);

  // Address and write data; writes to an out-of-range frame are dropped
  always_comb begin
    addr  = cmd.clear_step ? clr_r : {frame_r, idx};
    we    = cmd.clear_step | (cmd.wr & frame_ok_r);
    wdata = '0;
    if (!cmd.clear_step) begin
      case (cmd.wr_sel)
        WR_ALLOC: wdata = {PAGE_W'(next_frame_r), (FRAME_SHIFT-1)'(0), 1'b1};
        WR_LEAF:  wdata = {ppn_r, (FRAME_SHIFT-1)'(0), 1'b1};
        WR_UNMAP: wdata = {rd_data_r[ENTRY_W-1:1], 1'b0};
        default:  wdata = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[addr];
    end
  end

  // Clear pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r     <= KIND_QUERY;
      lvl_r      <= '0;
      frame_ok_r <= 1'b0;
    end else if (cmd.load) begin
      kind_r     <= in_data.kind;
      lvl_r      <= '0;
      frame_ok_r <= (PAGE_W'(root_r) < NF_PAGE);
    end else if (cmd.descend_entry) begin
      lvl_r      <= lvl_r + 1'b1;
      frame_ok_r <= ent_ok;
    end else if (cmd.descend_fresh) begin
      lvl_r      <= lvl_r + 1'b1;
      frame_ok_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vsh_r   <= in_data.virtual_page[VSH_W-1:0];
      ppn_r   <= in_data.physical_page;
      frame_r <= FRAME_W'(root_r);
    end else if (cmd.descend_entry) begin
      vsh_r   <= vsh_r << IDX_W;
      frame_r <= rd_data_r[FRAME_SHIFT +: FRAME_W];
    end else if (cmd.descend_fresh) begin
      vsh_r   <= vsh_r << IDX_W;
      frame_r <= next_frame_r[FRAME_W-1:0];
    end
  end

  // Configuration and frame allocator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r       <= '0;
      next_frame_r <= NF_W'(FIRST_FREE_RST);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ROOT_FRAME) begin
        root_r <= cfg_wdata[ROOT_W-1:0];
      end else if (cfg_index == CFG_FIRST_FREE_FRAME) begin
        next_frame_r <= NF_W'(cfg_wdata);
      end
    end else if (cmd.descend_fresh) begin
      next_frame_r <= next_frame_r + 1'b1;
    end
  end

  // Result register, shown for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r.mapped        <= cmd.fin_hit;
      out_data_r.found_page    <= cmd.fin_hit ? ent_frame : '0;
      out_data_r.out_of_frames <= cmd.fin_oof;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[design/fl_ptw_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module fl_ptw_checker
  import fl_ptw_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire out_item_t out_data
);

  // Reset starts the table clear, so no item may be taken right after it
  `FLP_ASSERT_RST(a_busy_after_reset, !rst_n |=> busy, "not busy after reset")

  // A real walk always occupies the block in the next cycle
  `FLP_ASSERT(a_walk_busy, start && !busy && in_data.kind != KIND_UNUSED |=> busy, "walk idle")

  // A hit and an allocation failure never share one result
  `FLP_ASSERT(a_hit_xor_oof, out_valid |-> !(out_data.mapped && out_data.out_of_frames), "hit+oof")

  // A miss carries no page
  `FLP_ASSERT(a_miss_zero, out_valid && !out_data.mapped |-> out_data.found_page == '0, "miss page")

endmodule

bind five_level_page_table_walker_unit fl_ptw_checker u_fl_ptw_checker (.*);

`default_nettype wire
